// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/msn_pkg.sv =====
// types and constants of the masked softmax normalizer
package msn_pkg;

  typedef struct packed {
    logic signed [15:0] logit;
    logic               legal;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        last_out;
  } out_word_t;

  typedef struct packed {
    logic               legal;
    logic signed [15:0] logit;
  } entry_t;

  localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;
  localparam logic [15:0]        PROB_MAX  = 16'hFFFF;
  localparam int                 EXP_W     = 17;
  localparam int                 DIV_STEPS = 33;

endpackage

// ===== src/masked_softmax_normalizer_core.sv =====
// masked softmax normalizer top level
// Words are loaded at one per cycle while full is low into one bank of a
// two-bank store; a set closes on last or on the MAX_ACTIONS-th word, and the
// front moves on to the other bank while the back works. For each set the
// back picks the set up, does the table lookup and sum for each entry (store
// read, index, table read, accumulate), forms the bit-serial reciprocal and
// then scales each entry (read, multiply, push). full rises while the back
// holds one closed set and a second closed set waits behind it.
`include "assert_macros.svh"

module masked_softmax_normalizer_core #(
  parameter int MAX_ACTIONS     = 64,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  msn_pkg::in_word_t  in_word,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output msn_pkg::out_word_t out_word
);

  localparam int CW = $clog2(MAX_ACTIONS + 1);
  localparam int IW = $clog2(MAX_ACTIONS);
  localparam int DW = 1 + CW + 16;
  localparam int OW = $bits(msn_pkg::out_word_t);

  logic               desc_push;
  logic               desc_bank;
  logic [CW-1:0]      desc_count;
  logic signed [15:0] desc_max;
  logic               desc_full;
  logic               desc_empty;
  logic               desc_pop;
  logic [DW-1:0]      desc_q;
  logic [IW:0]        rd_addr;
  msn_pkg::entry_t    rd_data;
  logic               out_push;
  msn_pkg::out_word_t back_word;
  logic               out_full;
  logic [OW-1:0]      out_q;

  msn_front #(.MAX_ACTIONS(MAX_ACTIONS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_word    (in_word),
    .full       (full),
    .desc_push  (desc_push),
    .desc_bank  (desc_bank),
    .desc_count (desc_count),
    .desc_max   (desc_max),
    .desc_full  (desc_full),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  msn_queue #(.W(DW), .DEPTH(2)) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .wdata ({desc_bank, desc_count, desc_max}),
    .full  (desc_full),
    .pop   (desc_pop),
    .rdata (desc_q),
    .empty (desc_empty)
  );

  msn_back #(.MAX_ACTIONS(MAX_ACTIONS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (!desc_empty),
    .desc_bank  (desc_q[DW-1]),
    .desc_count (desc_q[DW-2:16]),
    .desc_max   (desc_q[15:0]),
    .desc_pop   (desc_pop),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_push   (out_push),
    .out_word   (back_word),
    .out_full   (out_full)
  );

  msn_queue #(.W(OW), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (back_word),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_q),
    .empty (empty)
  );

  assign out_word = msn_pkg::out_word_t'(out_q);

  `ASSERT_NEVER(a_desc_overflow, clk, rst_n, desc_push && desc_full)
  `ASSERT_NEVER(a_out_overflow, clk, rst_n, out_push && out_full)
  `ASSERT_CLK(a_desc_pop_valid, clk, rst_n, desc_pop |-> !desc_empty)
  `ASSERT_CLK(a_last_frees_set, clk, rst_n, (out_push && back_word.last_out) |-> desc_pop)

endmodule

// ===== src/msn_queue.sv =====
// small register queue with push/full and pop/empty sides
module msn_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_r [DEPTH];
  logic [AW-1:0]   wptr_r;
  logic [AW-1:0]   rptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== src/msn_front.sv =====
// front end: loads words into a two-bank store, tracks the legal maximum, closes sets
module msn_front #(
  parameter int MAX_ACTIONS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  msn_pkg::in_word_t                     in_word,
  output logic                                  full,
  output logic                                  desc_push,
  output logic                                  desc_bank,
  output logic [$clog2(MAX_ACTIONS + 1)-1:0]    desc_count,
  output logic signed [15:0]                    desc_max,
  input  logic                                  desc_full,
  input  logic [$clog2(MAX_ACTIONS):0]          rd_addr,
  output msn_pkg::entry_t                       rd_data
);

  localparam int IW = $clog2(MAX_ACTIONS);
  localparam int CW = $clog2(MAX_ACTIONS + 1);

  msn_pkg::entry_t    mem [2 << IW];
  msn_pkg::entry_t    rd_data_r;
  logic [CW-1:0]      cnt_r;
  logic signed [15:0] max_r;
  logic               bank_r;
  logic               accept;
  logic [CW-1:0]      cnt_inc;
  logic signed [15:0] max_nxt;
  logic               close;

  assign full    = desc_full;
  assign accept  = push && !desc_full;
  assign cnt_inc = cnt_r + 1'b1;
  assign max_nxt = (in_word.legal && (in_word.logit > max_r)) ? in_word.logit : max_r;
  assign close   = in_word.last || (cnt_inc == CW'(MAX_ACTIONS));

  assign desc_push  = accept && close;
  assign desc_bank  = bank_r;
  assign desc_count = cnt_inc;
  assign desc_max   = max_nxt;
  assign rd_data    = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      max_r  <= msn_pkg::LOGIT_MIN;
      bank_r <= 1'b0;
    end else if (accept) begin
      if (close) begin
        cnt_r  <= '0;
        max_r  <= msn_pkg::LOGIT_MIN;
        bank_r <= !bank_r;
      end else begin
        cnt_r <= cnt_inc;
        max_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[{bank_r, cnt_r[IW-1:0]}] <= '{legal: in_word.legal, logit: in_word.logit};
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== src/msn_back.sv =====
// back end: exp lookup and sum, reciprocal, scaling of each entry
module msn_back #(
  parameter int MAX_ACTIONS     = 64,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  desc_valid,
  input  logic                                  desc_bank,
  input  logic [$clog2(MAX_ACTIONS + 1)-1:0]    desc_count,
  input  logic signed [15:0]                    desc_max,
  output logic                                  desc_pop,
  output logic [$clog2(MAX_ACTIONS):0]          rd_addr,
  input  msn_pkg::entry_t                       rd_data,
  output logic                                  out_push,
  output msn_pkg::out_word_t                    out_word,
  input  logic                                  out_full
);

  localparam int IW = $clog2(MAX_ACTIONS);
  localparam int CW = $clog2(MAX_ACTIONS + 1);
  localparam int TW = $clog2(EXP_TABLE_DEPTH);
  localparam int SW = IW + msn_pkg::EXP_W;
  localparam int EW = msn_pkg::EXP_W;
  localparam logic [63:0] RATE_ARG = (64'd1 << 36) / EXP_TABLE_DEPTH;

  typedef logic [EW-1:0] rom_t [EXP_TABLE_DEPTH];

  function automatic rom_t build_rom(logic [63:0] a);
    rom_t        rom;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    logic [63:0] r;
    term = 64'd1 << 32;
    pos  = term;
    neg  = '0;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * a) >> 32) / 64'(k);
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r = pos - neg;
    t = 64'd1 << 32;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      if (k > 0) begin
        t = (t * r + (64'd1 << 31)) >> 32;
      end
      rom[k] = EW'((t + 64'd32768) >> 16);
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_rom(RATE_ARG);

  typedef enum logic [3:0] {
    ST_IDLE, ST_E_RD, ST_E_IDX, ST_E_ROM, ST_E_ACC, ST_DIV, ST_O_RD, ST_O_MUL, ST_O_PUSH
  } state_t;

  state_t             st_r;
  logic               bank_r;
  logic [CW-1:0]      count_r;
  logic signed [15:0] max_r;
  logic [CW-1:0]      i_r;
  logic               zero_r;
  logic [TW-1:0]      idx_r;
  logic [EW-1:0]      rom_q_r;
  logic [SW-1:0]      sum_r;
  logic [SW:0]        rem_r;
  logic [15:0]        quo_r;
  logic [5:0]         dcnt_r;
  logic [EW-1:0]      recip_r;
  logic [EW-1:0]      exp_mem [MAX_ACTIONS];
  logic [EW-1:0]      exp_rd_r;
  logic [2*EW-1:0]    prod_r;

  logic [16:0]        diff;
  logic [25:0]        idx_prod;
  logic [EW-1:0]      exp_val;
  logic [SW:0]        rem_sh;
  logic               ge;
  logic [SW:0]        rem_nxt;
  logic [2*EW:0]      rounded;
  logic [2*EW-16:0]   scaled;
  logic               is_last;

  assign rd_addr  = {bank_r, i_r[IW-1:0]};
  assign diff     = {max_r[15], max_r} - {rd_data.logit[15], rd_data.logit};
  assign idx_prod = 26'(diff[11:0]) * 26'(EXP_TABLE_DEPTH);
  assign exp_val  = zero_r ? '0 : rom_q_r;
  assign rem_sh   = {rem_r[SW-1:0], (dcnt_r == 6'(msn_pkg::DIV_STEPS - 1))};
  assign ge       = (rem_sh >= {1'b0, sum_r});
  assign rem_nxt  = ge ? rem_sh - {1'b0, sum_r} : rem_sh;
  assign rounded  = {1'b0, prod_r} + (2*EW+1)'(32768);
  assign scaled   = rounded[2*EW:16];
  assign is_last  = (i_r + 1'b1 == count_r);

  assign out_push = (st_r == ST_O_PUSH) && !out_full;
  assign desc_pop = out_push && is_last;
  assign out_word = '{probability: (|scaled[2*EW-16:16]) ? msn_pkg::PROB_MAX : scaled[15:0],
                      last_out: is_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (desc_valid) begin
            bank_r  <= desc_bank;
            count_r <= desc_count;
            max_r   <= desc_max;
            i_r     <= '0;
            sum_r   <= '0;
            st_r    <= ST_E_RD;
          end
        end
        ST_E_RD: begin
          st_r <= ST_E_IDX;
        end
        ST_E_IDX: begin
          zero_r <= !rd_data.legal || (diff[16:12] != '0);
          idx_r  <= TW'(idx_prod >> 12);
          st_r   <= ST_E_ROM;
        end
        ST_E_ROM: begin
          rom_q_r <= EXP_ROM[idx_r];
          st_r    <= ST_E_ACC;
        end
        ST_E_ACC: begin
          sum_r <= sum_r + SW'(exp_val);
          if (is_last) begin
            rem_r  <= '0;
            quo_r  <= '0;
            dcnt_r <= 6'(msn_pkg::DIV_STEPS - 1);
            st_r   <= ST_DIV;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= ST_E_RD;
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[14:0], ge};
          if (dcnt_r == '0) begin
            recip_r <= (sum_r == '0) ? '0 : {quo_r, ge};
            i_r     <= '0;
            st_r    <= ST_O_RD;
          end else begin
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        ST_O_RD: begin
          st_r <= ST_O_MUL;
        end
        ST_O_MUL: begin
          prod_r <= exp_rd_r * recip_r;
          st_r   <= ST_O_PUSH;
        end
        ST_O_PUSH: begin
          if (!out_full) begin
            if (is_last) begin
              st_r <= ST_IDLE;
            end else begin
              i_r  <= i_r + 1'b1;
              st_r <= ST_O_RD;
            end
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_E_ACC) begin
      exp_mem[i_r[IW-1:0]] <= exp_val;
    end
    if (st_r == ST_O_RD) begin
      exp_rd_r <= exp_mem[i_r[IW-1:0]];
    end
  end

endmodule

// ===== sim/masked_softmax_normalizer_core_tb.sv =====
// testbench of the masked softmax normalizer: directed and random sets checked against a predictor
module masked_softmax_normalizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ACTIONS = 64;
  localparam int TABLE_DEPTH = 1024;
  localparam int HOLD_CYCLES = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  msn_pkg::in_word_t in_word = '0;
  msn_pkg::out_word_t out_word;

  masked_softmax_normalizer_core #(
    .MAX_ACTIONS(MAX_ACTIONS),
    .EXP_TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .in_word(in_word), .full(full),
    .empty(empty), .pop(pop), .out_word(out_word)
  );

  always #5 clk = ~clk;

  logic [16:0] exp_lut [TABLE_DEPTH];
  msn_pkg::out_word_t prob_queue [$];
  logic signed [15:0] set_logits [$];
  logic set_legals [$];
  logic signed [15:0] set_max;
  int errors = 0;
  int words_sent = 0;
  int words_popped = 0;
  int sets_closed = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  bit hold_taken = 0;

  task automatic build_exp_lut();
    longint unsigned a, term, pos, neg, t, r;
    a = (64'd1 << 36) / TABLE_DEPTH;
    term = 64'd1 << 32;
    pos = term;
    neg = 0;
    t = 64'd1 << 32;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * a) >> 32) / k;
      if (k % 2) neg += term;
      else pos += term;
    end
    r = pos - neg;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k > 0) t = (t * r + (64'd1 << 31)) >> 32;
      exp_lut[k] = 17'((t + 32768) >> 16);
    end
  endtask

  task automatic close_set();
    int unsigned n, d, sum;
    logic [16:0] e [MAX_ACTIONS];
    longint unsigned recip, p;
    msn_pkg::out_word_t w;
    n = set_logits.size();
    sum = 0;
    recip = 0;
    for (int i = 0; i < n; i++) begin
      e[i] = '0;
      if (set_legals[i]) begin
        d = 32'(int'(set_max) - int'(set_logits[i]));
        if (d < 4096) e[i] = exp_lut[(d * TABLE_DEPTH) >> 12];
      end
      sum += e[i];
    end
    if (sum != 0) recip = (64'd1 << 32) / sum;
    for (int i = 0; i < n; i++) begin
      p = (longint'(e[i]) * recip + 32768) >> 16;
      if (p > 65535) p = 65535;
      w.probability = 16'(p);
      w.last_out = (i + 1 == n);
      prob_queue.insert(prob_queue.size(), w);
    end
    set_logits.delete();
    set_legals.delete();
    set_max = msn_pkg::LOGIT_MIN;
    sets_closed++;
  endtask

  task automatic predict_word(msn_pkg::in_word_t w);
    set_logits.insert(set_logits.size(), w.logit);
    set_legals.insert(set_legals.size(), w.legal);
    if (w.legal && w.logit > set_max) set_max = w.logit;
    if (w.last || set_logits.size() == MAX_ACTIONS) close_set();
  endtask

  task automatic send_word(logic signed [15:0] logit, logic legal, logic last);
    int gap;
    msn_pkg::in_word_t w;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    w.logit = logit;
    w.legal = legal;
    w.last = last;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    predict_word(w);
    words_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (prob_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_set(int n, int lo, int hi, int legal_pct);
    for (int i = 0; i < n; i++)
      send_word(16'($urandom_range(0, hi - lo) + lo), $urandom_range(0, 99) < legal_pct,
                i == n - 1);
  endtask

  task automatic test_directed();
    send_word(16'sh0100, 1'b1, 1'b1);
    send_word(16'sh7FFF, 1'b0, 1'b0);
    send_word(msn_pkg::LOGIT_MIN, 1'b0, 1'b1);
    send_word(16'sh7FFF, 1'b1, 1'b0);
    send_word(msn_pkg::LOGIT_MIN, 1'b1, 1'b0);
    send_word(16'sh7000, 1'b1, 1'b0);
    send_word(16'sh7EFF, 1'b0, 1'b1);
    send_word(16'sh0000, 1'b1, 1'b0);
    send_word(-16'sh0FFF, 1'b1, 1'b0);
    send_word(-16'sh1000, 1'b1, 1'b0);
    send_word(16'sh0000, 1'b1, 1'b1);
    send_word(16'sh1234, 1'b1, 1'b0);
    send_word(16'sh1234, 1'b1, 1'b0);
    send_word(16'sh1234, 1'b1, 1'b1);
    send_word(msn_pkg::LOGIT_MIN, 1'b1, 1'b1);
    send_word(16'sh0000, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_set();
    send_set(MAX_ACTIONS + 1, -2048, 2047, 80);
    wait_drained();
  endtask

  task automatic test_random();
    int target;
    target = words_sent + 12;
    while (words_sent < target) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: send_set($urandom_range(1, 12), -32768, 32767, 50);
        1: send_set($urandom_range(1, 6), -32768, 32767, 20);
        default: send_set($urandom_range(1, 8), -1536, 1536, 85);
      endcase
    end
    no_idle = 0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    repeat (3) @(posedge clk);
    for (int s = 0; s < 3; s++) send_set($urandom_range(4, 6), -1024, 1024, 90);
    wait_drained();
  endtask

  initial begin
    int stall, held;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_req && !hold_taken) begin
        held = 0;
        pop <= 1'b0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_taken = 1;
      end else if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      words_popped++;
      if (prob_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: prob=%0d last=%0b",
                                   out_word.probability, out_word.last_out);
      end else begin
        msn_pkg::out_word_t exp_w;
        exp_w = prob_queue[0];
        prob_queue.delete(0);
        if (out_word !== exp_w) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected prob=%0d last=%0b, got prob=%0d last=%0b",
                     exp_w.probability, exp_w.last_out, out_word.probability,
                     out_word.last_out);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    build_exp_lut();
    set_max = msn_pkg::LOGIT_MIN;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_set();
    test_backpressure();
    test_random();
    repeat (200) @(posedge clk);
    if (prob_queue.size() != 0) errors++;
    $display("sent %0d words in %0d sets, checked %0d probabilities", words_sent,
             sets_closed, words_popped);
    $display("covered masking, saturation, overlong sets, stalls and full input");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
